>>> design/rsi_pkg.sv
// Package for the streaming RSI block: constants, controller/datapath command and status types.
// Used by rsi_ctrl, rsi_dp and rsi_streaming_indicator_unit.
package rsi_pkg;
    localparam int MAX_PERIOD = 1024;
    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = 64;
    localparam int PER_BITS   = 11;
    localparam int RSI_BITS   = 15;
    localparam int DIV_BITS   = 7;
    localparam logic [PER_BITS-1:0] PERIOD_RESET = 11'd14;
    localparam logic [RSI_BITS-1:0] RSI_HALF = 15'd12800;
    localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;

    typedef enum logic [2:0] {
        OP_NONE = 3'b001,
        OP_GAIN = 3'b010,
        OP_LOSS = 3'b100
    } t_div_sel;

    typedef struct packed {
        logic     load_in;    // capture price, compute difference, update state
        logic     start_div;  // start a division on selected operand
        t_div_sel div_sel;
        logic     start_rsi;  // start ratio division
        logic     out_load;   // present result
        logic     out_warm;
    } t_cmd;

    typedef struct packed {
        logic first;      // count was zero
        logic warm_more;  // still warming after this item
        logic div_busy;
    } t_sts;
endpackage

>>> design/rsi_ctrl.sv
// Controller state machine for the streaming RSI block.
// Depends on rsi_pkg; drives rsi_dp through t_cmd and reads t_sts.
module rsi_ctrl import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DECIDE= 6'b000010,
        S_DIVG  = 6'b000100,
        S_DIVL  = 6'b001000,
        S_RSI   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_warm, n_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_warm  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_warm  <= n_warm;
        end
    end

    always_comb begin
        n_state = r_state;
        n_warm  = r_warm;
        o_cmd   = '0;
        o_cmd.div_sel = OP_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // the datapath holds flags from the accepted item
                if (i_sts.first || i_sts.warm_more) begin
                    n_warm = 1'b0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.start_div = 1'b1;
                    o_cmd.div_sel = OP_GAIN;
                    n_state = S_DIVG;
                end
            end
            S_DIVG: begin
                if (!i_sts.div_busy) begin
                    o_cmd.start_div = 1'b1;
                    o_cmd.div_sel = OP_LOSS;
                    n_state = S_DIVL;
                end
            end
            S_DIVL: begin
                if (!i_sts.div_busy) begin
                    o_cmd.start_rsi = 1'b1;
                    n_state = S_RSI;
                end
            end
            S_RSI: begin
                if (!i_sts.div_busy) begin
                    n_warm = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_warm = r_warm;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> design/rsi_dp.sv
// Datapath for the streaming RSI block: state registers, shared radix-2 divider,
// output register. Depends on rsi_pkg; controlled by rsi_ctrl.
module rsi_dp import rsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PER_BITS-1:0]   i_period,
    input  logic [PRICE_BITS-1:0] i_close_price,
    input  t_cmd                  i_cmd,
    input  logic                  i_out_stall,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [RSI_BITS-1:0]   o_rsi_value,
    output logic                  o_warmed_up
);
    logic [PRICE_BITS-1:0] r_prev;
    logic [ACC_BITS-1:0]   r_gain, r_loss, r_up, r_dn;
    logic [PER_BITS-1:0]   r_count;
    logic [PER_BITS-1:0]   r_p;
    logic                  r_first, r_warm_more, r_warm_div;
    logic                  r_out_valid;
    logic [RSI_BITS-1:0]   r_rsi;
    logic [RSI_BITS-1:0]   r_ratio;   // ratio result, copied to output on load
    logic                  r_warm;

    // divider: 64-bit dividend and divisor, one quotient bit a cycle
    logic [ACC_BITS-1:0] r_q;
    logic [ACC_BITS:0]   r_rem;
    logic [ACC_BITS-1:0] r_dvs;
    logic [DIV_BITS-1:0] r_cnt;
    logic                r_busy;
    t_div_sel            r_sel;
    logic                r_rsi_op;

    logic [PER_BITS-1:0] eff_p;
    logic [ACC_BITS-1:0] d_up, d_dn;
    logic [ACC_BITS:0]   rem_sh, rem_sub;
    logic [ACC_BITS-1:0] src, wsrc, xsrc;
    logic [ACC_BITS+PER_BITS-1:0] prod;
    logic [ACC_BITS-1:0] prod_sat, add_sat;
    logic [ACC_BITS:0]   add_w;
    logic [ACC_BITS-1:0] g_s, l_s, sum_s;
    logic [5:0]          sh;
    logic [ACC_BITS:0]   up_sum, dn_sum;

    always_comb begin
        eff_p = i_period;
        if (i_period == '0) eff_p = PER_BITS'(1);
        if (i_period > PER_BITS'(MAX_PERIOD)) eff_p = PER_BITS'(MAX_PERIOD);
        d_up = '0;
        d_dn = '0;
        if (i_close_price > r_prev)
            d_up = ACC_BITS'(i_close_price - r_prev) << FRAC_BITS;
        else
            d_dn = ACC_BITS'(r_prev - i_close_price) << FRAC_BITS;
        up_sum = {1'b0, r_gain} + {1'b0, d_up};
        dn_sum = {1'b0, r_loss} + {1'b0, d_dn};
    end

    // Wilder numerator: saturated avg*(P-1)+x for the selected side, or the plain sum on the item that ends warm-up
    always_comb begin
        src  = (i_cmd.div_sel == OP_GAIN) ? r_gain : r_loss;
        xsrc = (i_cmd.div_sel == OP_GAIN) ? r_up : r_dn;
        prod = src * (r_p - PER_BITS'(1));
        prod_sat = (prod[ACC_BITS+PER_BITS-1:ACC_BITS] != '0) ? '1 : prod[ACC_BITS-1:0];
        add_w = {1'b0, prod_sat} + {1'b0, xsrc};
        add_sat = add_w[ACC_BITS] ? '1 : add_w[ACC_BITS-1:0];
        wsrc = r_warm_div ? src : add_sat;
    end

    // RSI operand scaling: shift both until below 2^47 (at most 17 steps)
    always_comb begin
        sh = '0;
        for (int k = 17; k >= 1; k--)
            if ((r_gain >> (k-1)) >= (64'd1 << 47) || (r_loss >> (k-1)) >= (64'd1 << 47))
                if (sh == '0) sh = 6'(k);
        g_s = r_gain >> sh;
        l_s = r_loss >> sh;
        sum_s = g_s + l_s;
    end

    always_comb begin
        rem_sh  = {r_rem[ACC_BITS-1:0], r_q[ACC_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_gain <= '0;
            r_loss <= '0;
            r_count <= '0;
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_p <= eff_p;
                r_up <= d_up;
                r_dn <= d_dn;
                r_first <= (r_count == '0);
                r_warm_more <= 1'b0;
                r_warm_div <= 1'b0;
                if (r_count == '0) begin
                    r_prev <= i_close_price;
                    r_count <= PER_BITS'(1);
                end else begin
                    r_prev <= i_close_price;
                    if (r_count <= eff_p) begin
                        r_gain <= up_sum[ACC_BITS] ? '1 : up_sum[ACC_BITS-1:0];
                        r_loss <= dn_sum[ACC_BITS] ? '1 : dn_sum[ACC_BITS-1:0];
                        r_count <= r_count + PER_BITS'(1);
                        r_warm_more <= (r_count + PER_BITS'(1)) <= eff_p;
                        r_warm_div  <= (r_count + PER_BITS'(1)) > eff_p;
                    end
                end
            end
            if (i_cmd.start_div) begin
                r_busy <= 1'b1;
                r_rsi_op <= 1'b0;
                r_sel <= i_cmd.div_sel;
                r_q <= wsrc;
                r_rem <= '0;
                r_dvs <= ACC_BITS'(r_p);
                r_cnt <= DIV_BITS'(ACC_BITS);
            end else if (i_cmd.start_rsi) begin
                r_busy <= (r_loss != '0);
                r_rsi_op <= 1'b1;
                // dividend g*25600 + sum/2 fits in 62 bits
                r_q <= g_s * 64'd25600 + (sum_s >> 1);
                r_rem <= '0;
                r_dvs <= sum_s;
                r_cnt <= DIV_BITS'(ACC_BITS);
                if (r_loss == '0) r_ratio <= RSI_FULL;
            end else if (r_busy) begin
                r_q <= {r_q[ACC_BITS-2:0], !rem_sub[ACC_BITS]};
                r_rem <= rem_sub[ACC_BITS] ? rem_sh : rem_sub;
                r_cnt <= r_cnt - DIV_BITS'(1);
                if (r_cnt == DIV_BITS'(1)) begin
                    r_busy <= 1'b0;
                    if (!r_rsi_op) begin
                        if (r_sel == OP_GAIN)
                            r_gain <= {r_q[ACC_BITS-2:0], !rem_sub[ACC_BITS]};
                        else
                            r_loss <= {r_q[ACC_BITS-2:0], !rem_sub[ACC_BITS]};
                    end else begin
                        r_ratio <= RSI_BITS'({r_q[ACC_BITS-2:0], !rem_sub[ACC_BITS]});
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_warm <= i_cmd.out_warm;
                r_rsi <= i_cmd.out_warm ? r_ratio : RSI_HALF;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.first     = r_first;
    assign o_sts.warm_more = r_warm_more;
    assign o_sts.div_busy  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_rsi_value = r_rsi;
    assign o_warmed_up = r_warm;
endmodule

>>> design/rsi_streaming_indicator_unit.sv
// Streaming Wilder RSI, top level: configuration register, controller and datapath.
// Depends on rsi_pkg, rsi_ctrl and rsi_dp.
// One closing price in, one RSI out (1/256 percent, warmed_up flag). Prices are taken
// one at a time. An item that gives a real RSI runs the shared one-bit-a-cycle divider
// for the gain average, then the loss average, then the ratio (the ratio division is
// skipped when the average loss is zero). The output register holds a result until
// taken; a stalled result holds the next result back, and the next price can be taken
// once the result is loaded. A warm-up item skips the divider.
module rsi_streaming_indicator_unit import rsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [PER_BITS-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PRICE_BITS-1:0] i_close_price,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [RSI_BITS-1:0]   o_rsi_value,
    output logic                  o_warmed_up
);
    logic [PER_BITS-1:0] r_period;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_period <= PERIOD_RESET;
        else if (i_cfg_valid) r_period <= i_cfg_data;
    end

    rsi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_out_busy(o_out_valid & i_out_stall), .i_sts(sts),
        .o_in_stall(o_in_stall), .o_cmd(cmd)
    );

    rsi_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_period(r_period),
        .i_close_price(i_close_price), .i_cmd(cmd), .i_out_stall(i_out_stall),
        .o_sts(sts), .o_out_valid(o_out_valid), .o_rsi_value(o_rsi_value),
        .o_warmed_up(o_warmed_up)
    );
endmodule

>>> bench/rsi_checker.sv
// Checker for the streaming RSI block: watches the config, price and result channels,
// predicts each RSI transaction and compares it. Depends on rsi_pkg.
module rsi_checker import rsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [PER_BITS-1:0]   i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PRICE_BITS-1:0] i_close_price,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [RSI_BITS-1:0]   i_rsi_value,
    input  logic                  i_warmed_up,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi;
        logic                warm;
    } t_rsi_result;

    logic [PER_BITS-1:0]   period_reg;
    logic [PRICE_BITS-1:0] last_price;
    logic [63:0]           gain_avg;
    logic [63:0]           loss_avg;
    int                    price_count;
    t_rsi_result           rsi_queue[$];

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] smooth(input logic [63:0] avg, input logic [63:0] x,
                                           input logic [63:0] p);
        logic [127:0] prod;
        logic [63:0]  scaled;
        prod   = {64'b0, avg} * {64'b0, p - 64'd1};
        scaled = (prod[127:64] != 0) ? '1 : prod[63:0];
        return add_sat(scaled, x) / p;
    endfunction

    function automatic logic [RSI_BITS-1:0] ratio(input logic [63:0] g, input logic [63:0] l);
        logic [63:0] s;
        logic [63:0] r;
        if (l == 0) return RSI_FULL;
        while (g >= (64'd1 << 47) || l >= (64'd1 << 47)) begin
            g = g >> 1;
            l = l >> 1;
        end
        s = g + l;
        r = (g * 64'd25600 + s / 2) / s;
        return r[RSI_BITS-1:0];
    endfunction

    function automatic t_rsi_result rsi_predict(input logic [PRICE_BITS-1:0] price);
        t_rsi_result res;
        logic [63:0] p;
        logic [63:0] up;
        logic [63:0] down;
        p = (period_reg == 0) ? 64'd1 : (period_reg > MAX_PERIOD) ? 64'(MAX_PERIOD)
                                                                 : 64'(period_reg);
        res.rsi  = RSI_HALF;
        res.warm = 1'b0;
        if (price_count == 0) begin
            last_price  = price;
            price_count = 1;
            return res;
        end
        up   = 0;
        down = 0;
        if (price > last_price) up = 64'(price - last_price) << FRAC_BITS;
        else down = 64'(last_price - price) << FRAC_BITS;
        last_price = price;
        if (price_count <= p) begin
            gain_avg = add_sat(gain_avg, up);
            loss_avg = add_sat(loss_avg, down);
            price_count++;
            if (price_count <= p) return res;
            gain_avg = gain_avg / p;
            loss_avg = loss_avg / p;
        end else begin
            gain_avg = smooth(gain_avg, up, p);
            loss_avg = smooth(loss_avg, down, p);
        end
        res.rsi  = ratio(gain_avg, loss_avg);
        res.warm = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsi_result want;
        if (!i_rst_n) begin
            period_reg     = PERIOD_RESET;
            last_price     = 0;
            gain_avg       = 0;
            loss_avg       = 0;
            price_count    = 0;
            o_fail_count   = 0;
            o_result_count = 0;
            rsi_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) period_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) rsi_queue.push_back(rsi_predict(i_close_price));
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (rsi_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: unexpected result rsi=%0d warm=%0b",
                                 i_rsi_value, i_warmed_up);
                end else begin
                    want = rsi_queue.pop_front();
                    if (want.rsi !== i_rsi_value || want.warm !== i_warmed_up) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"ERROR: result %0d expected rsi=%0d warm=%0b, ",
                                      "got rsi=%0d warm=%0b"},
                                     o_result_count, want.rsi, want.warm, i_rsi_value,
                                     i_warmed_up);
                    end
                end
            end
        end
        o_pending = rsi_queue.size();
    end
endmodule

>>> bench/rsi_streaming_indicator_unit_tb.sv
// Top of the RSI bench: clock, reset, price and period stimulus, final verdict.
// Depends on rsi_pkg, rsi_streaming_indicator_unit and rsi_checker.
module rsi_streaming_indicator_unit_tb;
    import rsi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [PER_BITS-1:0]   i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PRICE_BITS-1:0] i_close_price = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [RSI_BITS-1:0]   o_rsi_value;
    logic                  o_warmed_up;

    int fail_count;
    int pending;
    int result_count;
    int cycles = 0;
    int idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int price_total = 0;
    logic [PRICE_BITS-1:0] walk_price = 32'd100000;

    rsi_streaming_indicator_unit u_top (.*);

    rsi_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_close_price,
        .i_out_valid(o_out_valid), .i_out_stall, .i_rsi_value(o_rsi_value),
        .i_warmed_up(o_warmed_up), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (idle_mode == 2) i_out_stall <= ($urandom_range(99) < 66);
        else if (idle_mode == 3) i_out_stall <= ($urandom_range(99) < 25);
        else i_out_stall <= 1'b0;
    end

    task automatic write_period(input logic [PER_BITS-1:0] value);
        // stop sending and let the last transaction reach the checker first
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_price(input logic [PRICE_BITS-1:0] price);
        int gap;
        int pct;
        i_in_valid    <= 1'b1;
        i_close_price <= price;
        do @(posedge i_clk); while (o_in_stall);
        price_total++;
        idle_mode = (price_total / 50) % 4;
        pct = (idle_mode == 1) ? 66 : (idle_mode == 3) ? 25 : 0;
        gap = 0;
        while ($urandom_range(99) < pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [PRICE_BITS-1:0] next_price();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) walk_price = walk_price + $urandom_range(2000) - 1000;
        else if (pick < 8) walk_price = $urandom;
        else if (pick == 9) walk_price = $urandom_range(1) ? '1 : '0;
        return walk_price;
    endfunction

    task automatic run_phase(input logic [PER_BITS-1:0] period, input int count);
        write_period(period);
        repeat (count) begin
            send_price(next_price());
            // one long hold-off: let every result drain before sending more
            if (price_total == 700) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
    endtask

    logic [PRICE_BITS-1:0] warm_prices[20] = '{
        32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1, 2, 3, 3, 3, 2, 100, 50, 50, 7, 7,
        7, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };
    // with period one: fall, rise, flat (both averages zero), fall (no gain)
    logic [PRICE_BITS-1:0] unit_prices[4] = '{10, 20, 20, 5};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (warm_prices[k]) send_price(warm_prices[k]);
        write_period(11'd1);
        foreach (unit_prices[k]) send_price(unit_prices[k]);
        run_phase(11'd1, 140);
        run_phase(11'd0, 100);
        run_phase(11'd2, 120);
        run_phase(11'd2047, 40);
        run_phase(11'd1024, 1000);
        run_phase(11'd5, 100);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d prices, checked %0d results; periods 14,1,0,2,2047,1024,5.",
                 price_total, result_count);
        $display("Idle phases: none, sender gaps, receiver stalls, both; %0d mismatches.",
                 fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/rsi_pkg.sv
design/rsi_ctrl.sv
design/rsi_dp.sv
design/rsi_streaming_indicator_unit.sv
bench/rsi_checker.sv
bench/rsi_streaming_indicator_unit_tb.sv
